[hdl/cbm_pkg.sv]
// Shared types and constants of the cartridge bank mapper.
// Used by the control decoder, the RAM and the top level.
`timescale 1ns / 1ps

package cbm_pkg;

    // Access kind of a bus beat.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_SIZE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_BATTERY   = 2'd2;

    // RAM size codes.
    localparam logic [1:0] RAM_NONE = 2'd0;
    localparam logic [1:0] RAM_2K   = 2'd1;
    localparam logic [1:0] RAM_8K   = 2'd2;
    localparam logic [1:0] RAM_32K  = 2'd3;

    // Widest RAM offset: 32KB.
    localparam int unsigned RAM_OFF_W = 15;
    localparam int unsigned ROM_ADDR_W = 21;

    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // Configuration register file.
    typedef struct packed {
        logic [6:0] rom_bank_mask;
        logic [1:0] ram_size_code;
        logic       has_battery;
    } cfg_t;

    // One bus access.
    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    // Request to the cartridge RAM.
    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [RAM_OFF_W-1:0] index;
        logic [7:0]           wdata;
    } ram_req_t;

    // Result of one access apart from the RAM data byte.
    typedef struct packed {
        logic                  rom_read;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  save_request;
        logic                  from_ram;
    } res_t;

endpackage

[hdl/cbm_bus_if.sv]
// Input channel of the cartridge bank mapper: one bus access per beat.
// Depends on nothing but the field widths of the access.
`timescale 1ns / 1ps

interface cbm_bus_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

[hdl/cbm_result_if.sv]
// Output channel of the cartridge bank mapper: one result per beat.
// Depends on nothing but the field widths of the result.
`timescale 1ns / 1ps

interface cbm_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_read;
    logic [20:0] rom_address;
    logic        save_request;

    modport source (output valid, output read_data, output rom_read,
                    output rom_address, output save_request, input ready);
    modport sink   (input valid, input read_data, input rom_read,
                    input rom_address, input save_request, output ready);
endinterface

[hdl/cbm_ctrl.sv]
// Configuration registers, banking registers and address decode of the mapper.
// Depends on cbm_pkg for the item, request, result and configuration types.
`timescale 1ns / 1ps

module cbm_ctrl #(
    parameter int unsigned RAM_BYTES     = 32768,
    parameter int unsigned ROM_ADDR_BITS = 21
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  cbm_pkg::item_t                        item,
    input  logic                                  advance,
    output cbm_pkg::ram_req_t                     ram_req,
    output cbm_pkg::res_t                         res
);

    localparam logic [cbm_pkg::RAM_OFF_W-1:0] RAM_CAP =
        cbm_pkg::RAM_OFF_W'(RAM_BYTES - 1);
    localparam logic [cbm_pkg::ROM_ADDR_W-1:0] ROM_MASK =
        cbm_pkg::ROM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    cbm_pkg::cfg_t cfg_reg;
    logic          ram_enabled_reg, ram_enabled_next;
    logic [4:0]    low_bank_reg, low_bank_next;
    logic [1:0]    high_bank_reg, high_bank_next;
    logic          banking_mode_reg, banking_mode_next;

    logic                          is_read;
    logic                          in_low_rom, in_high_rom, in_ram;
    logic [6:0]                    bank;
    logic [cbm_pkg::RAM_OFF_W-1:0] size_mask;
    logic [cbm_pkg::RAM_OFF_W-1:0] ram_off;
    logic                          ram_ok;
    logic                          enable_value;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_bank_mask <= 7'h7F;
            cfg_reg.ram_size_code <= cbm_pkg::RAM_32K;
            cfg_reg.has_battery   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbm_pkg::CFG_ROM_BANK_MASK: cfg_reg.rom_bank_mask <= cfg_data;
                cbm_pkg::CFG_RAM_SIZE_CODE: cfg_reg.ram_size_code <= cfg_data[1:0];
                cbm_pkg::CFG_HAS_BATTERY:   cfg_reg.has_battery   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Address windows.
    assign is_read     = (item.kind == cbm_pkg::KIND_READ);
    assign in_low_rom  = (item.address[15:14] == 2'b00);
    assign in_high_rom = (item.address[15:14] == 2'b01);
    assign in_ram      = (item.address[15:13] == 3'b101);

    // RAM size in use, capped at the physical RAM.
    always_comb
    begin
        case (cfg_reg.ram_size_code)
            cbm_pkg::RAM_2K:  size_mask = 15'h07FF & RAM_CAP;
            cbm_pkg::RAM_8K:  size_mask = 15'h1FFF & RAM_CAP;
            cbm_pkg::RAM_32K: size_mask = 15'h7FFF & RAM_CAP;
            default:          size_mask = 15'h0000;
        endcase
    end

    assign ram_ok  = ram_enabled_reg && (cfg_reg.ram_size_code != cbm_pkg::RAM_NONE);
    assign ram_off = {2'b00, item.address[12:0]}
                   + (banking_mode_reg ? {high_bank_reg, 13'h0000} : 15'h0000);

    // ROM bank for the window being read.
    always_comb
    begin
        if (in_low_rom)
            bank = banking_mode_reg ? {high_bank_reg, 5'b00000} : 7'h00;
        else
            bank = {high_bank_reg, low_bank_reg};
    end

    // Result fields and RAM request.
    always_comb
    begin
        res.rom_read     = is_read && (in_low_rom || in_high_rom);
        res.rom_address  = res.rom_read
                         ? ({bank & cfg_reg.rom_bank_mask, item.address[13:0]} & ROM_MASK)
                         : '0;
        ram_req.rd       = is_read && in_ram && ram_ok;
        ram_req.wr       = !is_read && in_ram && ram_ok && advance;
        ram_req.index    = ram_off & size_mask;
        ram_req.wdata    = item.write_data;
        res.from_ram     = ram_req.rd;
        res.save_request = !is_read && (item.address[15:13] == 3'b000)
                         && cfg_reg.has_battery && !enable_value;
    end

    assign enable_value = (item.write_data[3:0] == 4'hA);

    // Banking register updates from control writes.
    always_comb
    begin
        ram_enabled_next  = ram_enabled_reg;
        low_bank_next     = low_bank_reg;
        high_bank_next    = high_bank_reg;
        banking_mode_next = banking_mode_reg;
        if (advance && !is_read)
        begin
            case (item.address[15:13])
                3'b000: ram_enabled_next = enable_value;
                3'b001: low_bank_next = (item.write_data[4:0] == 5'd0)
                                      ? 5'd1 : item.write_data[4:0];
                3'b010: high_bank_next = item.write_data[1:0];
                3'b011: banking_mode_next = item.write_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg  <= 1'b0;
            low_bank_reg     <= 5'd1;
            high_bank_reg    <= 2'd0;
            banking_mode_reg <= 1'b0;
        end
        else
        begin
            ram_enabled_reg  <= ram_enabled_next;
            low_bank_reg     <= low_bank_next;
            high_bank_reg    <= high_bank_next;
            banking_mode_reg <= banking_mode_next;
        end
    end

endmodule

[hdl/cbm_ram.sv]
// Cartridge RAM with one port, registered read data and a clearing pass after reset.
// Depends on cbm_pkg for the request type.
`timescale 1ns / 1ps

module cbm_ram #(
    parameter int unsigned RAM_BYTES = 32768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cbm_pkg::ram_req_t req,
    input  logic              rd_en,
    output logic [7:0]        rd_data,
    output logic              clearing
);

    localparam int unsigned RAM_AW = $clog2(RAM_BYTES);
    localparam logic [RAM_AW-1:0] LAST = RAM_AW'(RAM_BYTES - 1);

    logic [7:0]        mem [RAM_BYTES];
    logic [7:0]        rd_data_reg;
    logic              clearing_reg;
    logic [RAM_AW-1:0] clr_addr_reg;
    logic [RAM_AW-1:0] addr;

    assign addr = req.index[RAM_AW-1:0];

    // Clearing pass: one byte a cycle from address zero upwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + RAM_AW'(1);
            if (clr_addr_reg == LAST)
                clearing_reg <= 1'b0;
        end
    end

    // Memory array: clear or item write, and registered read.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_addr_reg] <= 8'h00;
        else if (req.wr)
            mem[addr] <= req.wdata;
        if (rd_en && req.rd)
            rd_data_reg <= mem[addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

[hdl/cartridge_bank_mapper_top.sv]
// Top level of the cartridge bank mapper: input stage, decode, RAM and result stage.
// Depends on cbm_pkg, cbm_bus_if, cbm_result_if, cbm_ctrl and cbm_ram.
//
// Usage: each beat on the bus channel is one CPU access (read or write, address,
// data). Each access gives exactly one beat on the result channel, in order:
// the RAM byte or 0xFF, a ROM read flag with the physical ROM address, and a
// save pulse when a battery-backed RAM is disabled.
// Path: an accepted access passes the input register, then the result register,
// loaded with the RAM's registered read. Throughput: one access per cycle unless
// stalled or clearing; the single RAM port serves one access a cycle.
// Reset: banking state returns to its reset values and the RAM is cleared by a
// pass over all RAM_BYTES bytes, one byte a cycle, during which bus.ready is low.
// Configuration writes are taken at any time, but are meant for an idle block.
// Stall: while the receiver holds result.ready low the result beat holds; one
// more access can still enter the input register before bus.ready drops.
`timescale 1ns / 1ps

module cartridge_bank_mapper_top #(
    parameter int unsigned RAM_BYTES     = 32768,
    parameter int unsigned ROM_ADDR_BITS = 21
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cbm_bus_if.sink                         bus,
    cbm_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              s1_valid_reg;
    cbm_pkg::item_t    s1_item_reg;
    logic              s2_valid_reg;
    cbm_pkg::res_t     s2_res_reg;

    logic              s2_load;
    logic              s1_adv;
    logic              accept;
    logic              clearing;
    logic [7:0]        ram_data;
    cbm_pkg::ram_req_t ram_req;
    cbm_pkg::res_t     res;

    // Pipeline handshake.
    assign s2_load   = !s2_valid_reg || result.ready;
    assign s1_adv    = s1_valid_reg && s2_load;
    assign bus.ready = !clearing && (!s1_valid_reg || s2_load);
    assign accept    = bus.valid && bus.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.kind       <= bus.kind;
            s1_item_reg.address    <= bus.address;
            s1_item_reg.write_data <= bus.write_data;
        end
    end

    cbm_ctrl #(
        .RAM_BYTES     (RAM_BYTES),
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (s1_item_reg),
        .advance   (s1_adv),
        .ram_req   (ram_req),
        .res       (res)
    );

    cbm_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rd_en    (s1_adv),
        .rd_data  (ram_data),
        .clearing (clearing)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s2_res_reg <= res;
    end

    assign result.valid        = s2_valid_reg;
    assign result.read_data    = s2_res_reg.from_ram ? ram_data : cbm_pkg::OPEN_BUS;
    assign result.rom_read     = s2_res_reg.rom_read;
    assign result.rom_address  = s2_res_reg.rom_address;
    assign result.save_request = s2_res_reg.save_request;

endmodule

[hdl/cbm_checker.sv]
// Port-level checks of the cartridge bank mapper, bound to the top level.
// Depends on cartridge_bank_mapper_top for the ports it watches.
`timescale 1ns / 1ps

module cbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  res_read_data,
    input logic        res_rom_read,
    input logic [20:0] res_rom_address,
    input logic        res_save_request
);

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_read_data)
        && $stable(res_rom_read) && $stable(res_rom_address)
        && $stable(res_save_request))
        else $error("result beat changed while stalled");

    // A ROM read never carries RAM data.
    a_rom_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rom_read |-> res_read_data == 8'hFF)
        else $error("ROM read returned a data byte");

    // The ROM address is zero unless a ROM read is flagged.
    a_rom_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_rom_read |-> res_rom_address == 21'd0)
        else $error("ROM address given without a ROM read");

    // A save pulse comes only from a control write, which reads nothing.
    a_save_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_save_request |-> !res_rom_read && res_read_data == 8'hFF)
        else $error("save pulse on a read access");

endmodule

bind cartridge_bank_mapper_top cbm_checker u_cbm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_read_data    (result.read_data),
    .res_rom_read     (result.rom_read),
    .res_rom_address  (result.rom_address),
    .res_save_request (result.save_request)
);
